>>> design/lcar_pkg.sv
// Shared types, constants and helpers for the load cell converter reader.
package lcar_pkg;

	// Serial word length of the converter and width of the result fields
	localparam int DATA_BITS = 24;
	localparam int OUT_W     = 24;
	localparam int GAP_W     = 16;
	localparam int WIDE_W    = (DATA_BITS > OUT_W) ? DATA_BITS : OUT_W;

	// Bit counter holds 0..DATA_BITS, divide counter holds 0..DATA_BITS-1
	localparam int CNT_W     = $clog2(DATA_BITS + 1);
	localparam int DCNT_W    = $clog2(DATA_BITS);

	localparam logic [DATA_BITS-1:0] RAW_FLIP  = DATA_BITS'(1) << (DATA_BITS - 1);
	localparam logic [OUT_W-1:0]     OUT_MAX   = {OUT_W{1'b1}};
	localparam logic [GAP_W-1:0]     GAP_RESET = GAP_W'(475);
	localparam logic [CNT_W-1:0]     BIT_LAST  = CNT_W'(DATA_BITS);
	localparam logic [DCNT_W-1:0]    DIV_FIRST = DCNT_W'(DATA_BITS - 1);

	// Queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	// Request codes on the mode field
	localparam logic [1:0] MODE_TARE  = 2'd1;
	localparam logic [1:0] MODE_WEIGH = 2'd2;

	typedef enum logic [1:0] {
		JOB_NONE  = 2'd0,
		JOB_TARE  = 2'd1,
		JOB_WEIGH = 2'd2
	} job_t;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_WAIT       = 3'd1,
		PH_HIGH       = 3'd2,
		PH_LOW        = 3'd3,
		PH_EXTRA_HIGH = 3'd4,
		PH_EXTRA_LOW  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_DIV  = 2'd1,
		BK_DONE = 2'd2
	} back_t;

	// One classified tick, front to back
	typedef struct packed {
		logic                 sck;
		logic                 busy;
		logic                 fin;
		job_t                 job;
		logic [DATA_BITS-1:0] raw;
	} rec_t;

	// Low OUT_W bits of a reading, zero-extended when the reading is narrower
	function automatic logic [OUT_W-1:0] to_out(input logic [DATA_BITS-1:0] v);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(v);
		return w[OUT_W-1:0];
	endfunction

	// Quotient clipped to the output range
	function automatic logic [OUT_W-1:0] sat_out(input logic [DATA_BITS-1:0] v);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(v);
		if (w > WIDE_W'(OUT_MAX))
			return OUT_MAX;
		return w[OUT_W-1:0];
	endfunction

endpackage

>>> design/lcar_ifs.sv
// Handshake channel interfaces: tick input, result output, configuration write.
interface lcar_tick_if import lcar_pkg::*;;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic       dout;

	modport source (output valid, mode, dout, input ready);
	modport sink   (input valid, mode, dout, output ready);
endinterface

interface lcar_result_if import lcar_pkg::*;;
	logic             valid;
	logic             ready;
	logic             sck;
	logic             busy_res;
	logic [OUT_W-1:0] raw_count;
	logic [OUT_W-1:0] tare_count;
	logic [OUT_W-1:0] weight;
	logic             weight_done;

	modport source (output valid, sck, busy_res, raw_count, tare_count, weight, weight_done,
		input ready);
	modport sink   (input valid, sck, busy_res, raw_count, tare_count, weight, weight_done,
		output ready);
endinterface

interface lcar_cfg_if import lcar_pkg::*;;
	logic             valid;
	logic             ready;
	logic [GAP_W-1:0] gap_value;

	modport source (output valid, gap_value, input ready);
	modport sink   (input valid, gap_value, output ready);
endinterface

>>> design/lcar_front.sv
// Front end: takes ticks, runs the serial clock sequencer, classifies each tick.
module lcar_front import lcar_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	lcar_tick_if.sink     tick,
	input  logic          q_full,
	output logic          q_push,
	output rec_t          q_data
);

	phase_t               phase_q, phase_d;
	logic                 sck_q, sck_d;
	logic [CNT_W-1:0]     bit_cnt_q, bit_cnt_d;
	logic [DATA_BITS-1:0] shift_q, shift_d;
	job_t                 job_q, job_d;
	logic                 fin;
	logic                 acc;

	assign tick.ready = !q_full;
	assign acc        = tick.valid && !q_full;

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			sck_q     <= 1'b0;
			bit_cnt_q <= '0;
			shift_q   <= '0;
			job_q     <= JOB_NONE;
		end else if (acc) begin
			phase_q   <= phase_d;
			sck_q     <= sck_d;
			bit_cnt_q <= bit_cnt_d;
			shift_q   <= shift_d;
			job_q     <= job_d;
		end
	end

	// Next state for one tick
	always_comb begin
		phase_d   = phase_q;
		sck_d     = sck_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		job_d     = job_q;
		fin       = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (tick.mode inside {MODE_TARE, MODE_WEIGH}) begin
					job_d     = (tick.mode == MODE_TARE) ? JOB_TARE : JOB_WEIGH;
					sck_d     = 1'b0;
					shift_d   = '0;
					bit_cnt_d = '0;
					phase_d   = PH_WAIT;
				end
			end
			PH_WAIT: begin
				// converter pulls data-out low when a conversion is ready
				if (!tick.dout) begin
					sck_d     = 1'b1;
					bit_cnt_d = '0;
					shift_d   = '0;
					phase_d   = PH_HIGH;
				end
			end
			PH_HIGH: begin
				sck_d     = 1'b0;
				shift_d   = {shift_q[DATA_BITS-2:0], tick.dout};
				bit_cnt_d = bit_cnt_q + CNT_W'(1);
				phase_d   = (bit_cnt_d >= BIT_LAST) ? PH_EXTRA_HIGH : PH_LOW;
			end
			PH_LOW: begin
				sck_d   = 1'b1;
				phase_d = PH_HIGH;
			end
			PH_EXTRA_HIGH: begin
				// extra pulse selects gain 128 for the next conversion
				sck_d   = 1'b1;
				phase_d = PH_EXTRA_LOW;
			end
			PH_EXTRA_LOW: begin
				sck_d   = 1'b0;
				fin     = 1'b1;
				job_d   = JOB_NONE;
				phase_d = PH_IDLE;
			end
			default: begin
				sck_d   = 1'b0;
				job_d   = JOB_NONE;
				phase_d = PH_IDLE;
			end
		endcase
	end

	// Classified word for the back end
	assign q_push      = acc;
	assign q_data.sck  = sck_d;
	assign q_data.busy = (phase_d != PH_IDLE);
	assign q_data.fin  = fin;
	assign q_data.job  = job_q;
	assign q_data.raw  = shift_q ^ RAW_FLIP;

	a_bit_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q <= BIT_LAST)
		else $error("bit counter past word length");

endmodule

>>> design/lcar_queue.sv
// Short FIFO of classified ticks between front and back.
module lcar_queue import lcar_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_data,
	output logic full,
	input  logic pop,
	output rec_t pop_data,
	output logic empty
);

	rec_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = ent_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

>>> design/lcar_back.sv
// Back end: keeps readings, runs the serial weight divide, drives the result register.
module lcar_back import lcar_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [GAP_W-1:0] divisor,
	input  logic             q_empty,
	input  rec_t             q_data,
	output logic             q_pop,
	lcar_result_if.source    result
);

	back_t                st_q, st_d;
	logic [DCNT_W-1:0]    dcnt_q;
	logic [DATA_BITS-1:0] quo_q;
	logic [GAP_W-1:0]     rem_q;
	logic                 sck_hold_q, busy_hold_q;
	logic [DATA_BITS-1:0] last_raw_q, tare_q;
	logic [OUT_W-1:0]     weight_q;

	logic                 out_valid_q;
	logic                 out_sck_q, out_busy_q, out_done_q;
	logic [OUT_W-1:0]     out_raw_q, out_tare_q, out_weight_q;

	logic                 out_free;
	logic                 div_start;
	logic                 out_load;
	logic                 take_fin;
	logic [GAP_W:0]       trial;
	logic                 qbit;
	logic [DATA_BITS-1:0] raw_nxt, tare_nxt;
	logic [OUT_W-1:0]     weight_nxt;
	logic                 sck_nxt, busy_nxt, done_nxt;

	assign out_free = !out_valid_q || result.ready;

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= BK_IDLE;
		else
			st_q <= st_d;
	end

	// Pop, divide and result control
	always_comb begin
		st_d      = st_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (st_q)
			BK_IDLE: begin
				if (!q_empty && out_free) begin
					q_pop = 1'b1;
					if (q_data.fin && q_data.job == JOB_WEIGH && q_data.raw > tare_q) begin
						div_start = 1'b1;
						st_d      = BK_DIV;
					end else begin
						out_load = 1'b1;
					end
				end
			end
			BK_DIV: begin
				if (dcnt_q == '0)
					st_d = BK_DONE;
			end
			BK_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					st_d     = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	// One restoring divide step
	assign trial = {rem_q, quo_q[DATA_BITS-1]};
	assign qbit  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk) begin
		if (div_start) begin
			quo_q       <= q_data.raw - tare_q;
			rem_q       <= '0;
			dcnt_q      <= DIV_FIRST;
			sck_hold_q  <= q_data.sck;
			busy_hold_q <= q_data.busy;
		end else if (st_q == BK_DIV) begin
			quo_q  <= {quo_q[DATA_BITS-2:0], qbit};
			rem_q  <= qbit ? GAP_W'(trial - {1'b0, divisor}) : trial[GAP_W-1:0];
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
	end

	// Values the delivered word shows
	assign take_fin   = q_pop && q_data.fin;
	assign raw_nxt    = take_fin ? q_data.raw : last_raw_q;
	assign tare_nxt   = (take_fin && q_data.job == JOB_TARE) ? q_data.raw : tare_q;
	assign done_nxt   = (st_q == BK_DONE);
	assign weight_nxt = done_nxt ? sat_out(quo_q) : weight_q;
	assign sck_nxt    = done_nxt ? sck_hold_q : q_data.sck;
	assign busy_nxt   = done_nxt ? busy_hold_q : q_data.busy;

	// Stored readings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q <= '0;
			tare_q     <= '0;
			weight_q   <= '0;
		end else begin
			last_raw_q <= raw_nxt;
			tare_q     <= tare_nxt;
			if (out_load)
				weight_q <= weight_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else
			out_valid_q <= out_load || (out_valid_q && !result.ready);
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sck_q    <= sck_nxt;
			out_busy_q   <= busy_nxt;
			out_raw_q    <= to_out(raw_nxt);
			out_tare_q   <= to_out(tare_nxt);
			out_weight_q <= weight_nxt;
			out_done_q   <= done_nxt;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.sck         = out_sck_q;
	assign result.busy_res    = out_busy_q;
	assign result.raw_count   = out_raw_q;
	assign result.tare_count  = out_tare_q;
	assign result.weight      = out_weight_q;
	assign result.weight_done = out_done_q;

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (st_q == BK_IDLE))
		else $error("queue popped while divide in progress");

endmodule

>>> design/load_cell_adc_reader.sv
// Top level of the load cell converter reader: channels, divisor register, front/queue/back.
//
//  channel  dir  word                                                    done when
//  tick     in   mode[1:0], dout                                         valid & ready
//  result   out  sck, busy_res, raw_count, tare_count, weight,
//                weight_done (24-bit counts)                             valid & ready
//  cfg      in   gap_value[15:0]                                         valid & ready
//
// One tick per cycle passes the front end while the queue is not full; each tick yields
// one result word. A tick that ends a weigh reading above tare stays in the back end
// for the one-bit-per-cycle restoring divider before its result word is loaded.
// The two-entry queue lets the front take two more ticks while the back divides or
// the result side stalls; after that tick.ready drops. Reset clears the sequencer,
// the stored readings and the divisor (to 475); no clearing pass. A gap_value of
// zero divides by one.
module load_cell_adc_reader import lcar_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	lcar_tick_if.sink     tick,
	lcar_result_if.source result,
	lcar_cfg_if.sink      cfg
);

	logic [GAP_W-1:0] gap_q;
	logic [GAP_W-1:0] divisor;
	logic             q_full, q_empty, q_push, q_pop;
	rec_t             q_in, q_out;

	// Divisor register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gap_q <= GAP_RESET;
		else if (cfg.valid)
			gap_q <= cfg.gap_value;
	end

	assign divisor = (gap_q == '0) ? GAP_W'(1) : gap_q;

	lcar_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_in)
	);

	lcar_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	lcar_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.divisor (divisor),
		.q_empty (q_empty),
		.q_data  (q_out),
		.q_pop   (q_pop),
		.result  (result)
	);

	a_sck_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.sck) |-> result.busy_res)
		else $error("serial clock high outside a reading");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.weight_done) |-> (!result.busy_res && !result.sck))
		else $error("weight update reported mid reading");

endmodule
